/* rtl/core/housekeeping_report_scheduler_assert.svh */
// Assertion macros for the housekeeping report scheduler.
// Depends on nothing; files that assert include it and provide clk_i and rst_ni.
`ifndef HOUSEKEEPING_REPORT_SCHEDULER_ASSERT_SVH
`define HOUSEKEEPING_REPORT_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("Housekeeping scheduler assertion failed.");
`define HRS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("Housekeeping scheduler reset assertion failed.");
`else
`define HRS_ASSERT(lbl, prop)
`define HRS_ASSERT_RST(lbl, prop)
`endif
`endif

/* rtl/core/hrs_pkg.sv */
// Package of the housekeeping report scheduler: sizes, codes and the sequencer state type.
// Depends on nothing; used by housekeeping_report_scheduler.
package hrs_pkg;

  localparam int unsigned NumStructures = 8;
  localparam int unsigned MaxList       = 16;

  localparam int unsigned StructIdxW = (NumStructures > 1) ? $clog2(NumStructures) : 1;
  localparam int unsigned ListIdxW   = (MaxList > 1) ? $clog2(MaxList) : 1;
  localparam int unsigned ListCntW   = $clog2(MaxList + 1);

  localparam int unsigned PeriodW    = 16;
  localparam int unsigned PeriodRst  = 10;
  localparam int unsigned BytesSeenW = 9;

  localparam logic OpTick = 1'b0;
  localparam logic OpTc   = 1'b1;

  localparam logic [1:0] SubEnable  = 2'd0;
  localparam logic [1:0] SubDisable = 2'd1;
  localparam logic [1:0] SubOneShot = 2'd2;
  localparam logic [1:0] SubOther   = 2'd3;

  localparam logic KindStatus = 1'b0;
  localparam logic KindReport = 1'b1;

  localparam logic [2:0] StatOk         = 3'd0;
  localparam logic [2:0] StatBadLength  = 3'd1;
  localparam logic [2:0] StatBadParam   = 3'd2;
  localparam logic [2:0] StatUnknownId  = 3'd3;
  localparam logic [2:0] StatUnknownSub = 3'd4;
  localparam logic [2:0] StatTooLong    = 3'd5;

  typedef enum logic [1:0] {
    StIdle,
    StTick,
    StList,
    StStatus
  } state_e;

endpackage

/* rtl/core/housekeeping_report_scheduler.sv */
// Housekeeping report scheduler: enable flags, tick phase counter and telecommand handling.
// Depends on hrs_pkg and housekeeping_report_scheduler_assert.svh.
//
// Usage: the input channel carries one word per tick or telecommand byte; the
// output channel returns report requests and completion status words. The
// period register is written through its own channel, which is always ready.
// A tick that does not generate, or a non-final byte, leaves the sequencer idle.
// A generating tick with a structure enabled scans the structures in order up to
// the last enabled one, one per cycle while the output is free. A final byte
// that passes the checks walks the stored list, one entry per cycle (for a
// one-shot list only while the output is free), then gives the status word; a
// rejected telecommand gives only its status word. The input is not ready while
// a run is in progress and is ready again in the cycle after its last word is
// loaded into the output register, which lets an item be accepted while that
// word still waits. When the receiver stalls, the output register holds its
// word and no other word is loaded. Reset enables structure 1, clears the phase,
// the collection state and the output, and sets the period to 10.
`include "housekeeping_report_scheduler_assert.svh"

module housekeeping_report_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [1:0]  subtype_i,
  input  logic        has_byte_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [2:0]  status_o,
  output logic [3:0]  report_id_o,
  output logic [7:0]  enabled_flags_o,
  output logic        run_end_o
);

  hrs_pkg::state_e state_q, state_d;

  logic [hrs_pkg::PeriodW-1:0]       period_q, phase_q, phase_d;
  logic [hrs_pkg::NumStructures-1:0] mask_q, mask_d;
  logic [7:0]                        id_list_q [hrs_pkg::MaxList];
  logic [hrs_pkg::BytesSeenW-1:0]    bytes_seen_q, bytes_seen_d;
  logic [7:0]                        dcount_q, dcount_d;
  logic                              invalid_q, invalid_d;

  logic [hrs_pkg::StructIdxW-1:0]    tick_idx_q, tick_idx_d;
  logic [hrs_pkg::ListIdxW-1:0]      scan_idx_q, scan_idx_d;
  logic [hrs_pkg::ListCntW-1:0]      scan_cnt_q, scan_cnt_d;
  logic [1:0]                        sub_q, sub_d;
  logic [2:0]                        stat_q, stat_d;

  logic       out_valid_q;
  logic       kind_q, end_q;
  logic [2:0] ostat_q;
  logic [3:0] rid_q;
  logic [7:0] flags_q;

  logic       accept, slot_free, tick_gen, list_ok, list_wr;
  logic       tick_last, scan_last;
  logic [hrs_pkg::PeriodW-1:0] phase_inc, period_eff;
  logic [hrs_pkg::BytesSeenW-1:0] bs_next, bs_dec;
  logic [7:0] dc_next, cur_id;
  logic       inv_next;
  logic [2:0] chk_stat;

  logic       emit, emit_kind, emit_end;
  logic [2:0] emit_stat;
  logic [3:0] emit_rid;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == hrs_pkg::StIdle);
  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || out_ready_i;

  assign period_eff = (period_q == '0) ? hrs_pkg::PeriodW'(1) : period_q;
  assign phase_inc  = phase_q + hrs_pkg::PeriodW'(1);
  assign tick_gen   = (phase_inc >= period_eff);

  assign bs_next  = (bytes_seen_q == {hrs_pkg::BytesSeenW{1'b1}}) ? bytes_seen_q
                                                                 : bytes_seen_q + 1'b1;
  assign bs_dec   = bytes_seen_q - 1'b1;
  assign dc_next  = (bytes_seen_q == '0) ? data_byte_i : dcount_q;
  assign inv_next = invalid_q || ((bytes_seen_q != '0) &&
                    ((data_byte_i == 8'd0) || (data_byte_i > 8'(hrs_pkg::NumStructures))));
  assign list_wr  = (bytes_seen_q != '0) &&
                    (bs_dec < hrs_pkg::BytesSeenW'(hrs_pkg::MaxList));

  always_comb begin
    if (subtype_i == hrs_pkg::SubOther) begin
      chk_stat = hrs_pkg::StatUnknownSub;
    end else if (bs_next != (hrs_pkg::BytesSeenW'(dc_next) + hrs_pkg::BytesSeenW'(1))) begin
      chk_stat = hrs_pkg::StatBadLength;
    end else if (dc_next == 8'd0) begin
      chk_stat = hrs_pkg::StatBadParam;
    end else if (dc_next > 8'(hrs_pkg::MaxList)) begin
      chk_stat = hrs_pkg::StatTooLong;
    end else if (inv_next) begin
      chk_stat = hrs_pkg::StatUnknownId;
    end else begin
      chk_stat = hrs_pkg::StatOk;
    end
  end
  assign list_ok = (chk_stat == hrs_pkg::StatOk);

  assign tick_last = (((mask_q >> tick_idx_q) >> 1) == '0);
  assign scan_last = ((hrs_pkg::ListCntW'(scan_idx_q) + hrs_pkg::ListCntW'(1)) == scan_cnt_q);
  assign cur_id    = id_list_q[scan_idx_q];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      hrs_pkg::StIdle: begin
        if (accept) begin
          if (opcode_i == hrs_pkg::OpTick) begin
            if (tick_gen && (mask_q != '0)) begin
              state_d = hrs_pkg::StTick;
            end
          end else if (!has_byte_i) begin
            state_d = hrs_pkg::StStatus;
          end else if (last_i) begin
            state_d = list_ok ? hrs_pkg::StList : hrs_pkg::StStatus;
          end
        end
      end
      hrs_pkg::StTick: begin
        if (slot_free && (tick_last ||
            (tick_idx_q == hrs_pkg::StructIdxW'(hrs_pkg::NumStructures - 1)))) begin
          state_d = hrs_pkg::StIdle;
        end
      end
      hrs_pkg::StList: begin
        if ((slot_free || (sub_q != hrs_pkg::SubOneShot)) && scan_last) begin
          state_d = hrs_pkg::StStatus;
        end
      end
      hrs_pkg::StStatus: begin
        if (slot_free) begin
          state_d = hrs_pkg::StIdle;
        end
      end
      default: state_d = hrs_pkg::StIdle;
    endcase
  end

  // Sequencer outputs and datapath updates.
  always_comb begin
    phase_d      = phase_q;
    mask_d       = mask_q;
    bytes_seen_d = bytes_seen_q;
    dcount_d     = dcount_q;
    invalid_d    = invalid_q;
    tick_idx_d   = tick_idx_q;
    scan_idx_d   = scan_idx_q;
    scan_cnt_d   = scan_cnt_q;
    sub_d        = sub_q;
    stat_d       = stat_q;
    emit         = 1'b0;
    emit_kind    = hrs_pkg::KindStatus;
    emit_stat    = hrs_pkg::StatOk;
    emit_rid     = 4'd0;
    emit_end     = 1'b0;
    case (state_q)
      hrs_pkg::StIdle: begin
        if (accept) begin
          if (opcode_i == hrs_pkg::OpTick) begin
            phase_d    = tick_gen ? '0 : phase_inc;
            tick_idx_d = '0;
          end else if (!has_byte_i) begin
            stat_d       = (subtype_i == hrs_pkg::SubOther) ? hrs_pkg::StatUnknownSub
                                                            : hrs_pkg::StatBadLength;
            bytes_seen_d = '0;
            dcount_d     = 8'd0;
            invalid_d    = 1'b0;
          end else if (last_i) begin
            stat_d       = chk_stat;
            sub_d        = subtype_i;
            scan_idx_d   = '0;
            scan_cnt_d   = hrs_pkg::ListCntW'(dc_next);
            bytes_seen_d = '0;
            dcount_d     = 8'd0;
            invalid_d    = 1'b0;
          end else begin
            bytes_seen_d = bs_next;
            dcount_d     = dc_next;
            invalid_d    = inv_next;
          end
        end
      end
      hrs_pkg::StTick: begin
        if (slot_free) begin
          emit       = mask_q[tick_idx_q];
          emit_kind  = hrs_pkg::KindReport;
          emit_rid   = 4'(tick_idx_q) + 4'd1;
          emit_end   = tick_last;
          tick_idx_d = tick_idx_q + 1'b1;
        end
      end
      hrs_pkg::StList: begin
        if (sub_q == hrs_pkg::SubOneShot) begin
          if (slot_free) begin
            emit       = 1'b1;
            emit_kind  = hrs_pkg::KindReport;
            emit_rid   = 4'(cur_id);
            scan_idx_d = scan_idx_q + 1'b1;
          end
        end else begin
          if (sub_q == hrs_pkg::SubEnable) begin
            mask_d[hrs_pkg::StructIdxW'(cur_id - 8'd1)] = 1'b1;
          end else begin
            mask_d[hrs_pkg::StructIdxW'(cur_id - 8'd1)] = 1'b0;
          end
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      hrs_pkg::StStatus: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = hrs_pkg::KindStatus;
          emit_stat = stat_q;
          emit_end  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hrs_pkg::StIdle;
      period_q     <= hrs_pkg::PeriodW'(hrs_pkg::PeriodRst);
      phase_q      <= '0;
      mask_q       <= hrs_pkg::NumStructures'(1);
      bytes_seen_q <= '0;
      dcount_q     <= 8'd0;
      invalid_q    <= 1'b0;
      tick_idx_q   <= '0;
      scan_idx_q   <= '0;
      scan_cnt_q   <= '0;
      sub_q        <= hrs_pkg::SubEnable;
      stat_q       <= hrs_pkg::StatOk;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      mask_q       <= mask_d;
      bytes_seen_q <= bytes_seen_d;
      dcount_q     <= dcount_d;
      invalid_q    <= invalid_d;
      tick_idx_q   <= tick_idx_d;
      scan_idx_q   <= scan_idx_d;
      scan_cnt_q   <= scan_cnt_d;
      sub_q        <= sub_d;
      stat_q       <= stat_d;
      if (cfg_valid_i && cfg_ready_o) begin
        period_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (opcode_i == hrs_pkg::OpTc) && has_byte_i && list_wr) begin
      id_list_q[bs_dec[hrs_pkg::ListIdxW-1:0]] <= data_byte_i;
    end
    if (emit) begin
      kind_q  <= emit_kind;
      ostat_q <= emit_stat;
      rid_q   <= emit_rid;
      flags_q <= 8'(mask_q);
      end_q   <= emit_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign status_o        = ostat_q;
  assign report_id_o     = rid_q;
  assign enabled_flags_o = flags_q;
  assign run_end_o       = end_q;

  `HRS_ASSERT(a_status_ends_run, (out_valid_o && (kind_o == hrs_pkg::KindStatus)) |-> run_end_o)
  `HRS_ASSERT(a_report_ok,
              (out_valid_o && (kind_o == hrs_pkg::KindReport)) |->
              ((status_o == hrs_pkg::StatOk) && (report_id_o != 4'd0)))
  `HRS_ASSERT(a_run_end_idle, (emit && emit_end) |=> (state_q == hrs_pkg::StIdle))
  `HRS_ASSERT(a_mask_list_only, (state_q != hrs_pkg::StList) |=> (mask_q == $past(mask_q)))
  `HRS_ASSERT_RST(a_reset_empty, !rst_ni |=> (!out_valid_q && (state_q == hrs_pkg::StIdle)))

endmodule

/* tb/hk_report_checker.sv */
// Checker for the housekeeping report scheduler: predicts every output word from the
// accepted input and configuration words and compares them in order of arrival.
// Depends on hrs_pkg; instantiated by the testbench top beside the block.
module hk_report_checker
  import hrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        opcode_i,
  input  logic [1:0]  subtype_i,
  input  logic        has_byte_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        kind_i,
  input  logic [2:0]  status_i,
  input  logic [3:0]  report_id_i,
  input  logic [7:0]  enabled_flags_i,
  input  logic        run_end_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [3:0] report_id;
    logic [7:0] flags;
    logic       run_end;
  } hk_word_t;

  hk_word_t              awaited_words[$];
  hk_word_t              got_word;
  hk_word_t              want_word;
  logic [PeriodW-1:0]    period_q;
  logic [PeriodW-1:0]    phase_q;
  logic [7:0]            enable_mask;
  logic [7:0]            id_list [MaxList];
  logic [BytesSeenW-1:0] bytes_seen;
  logic [7:0]            declared_cnt;
  logic                  bad_id_seen;
  int unsigned           error_cnt;

  function automatic hk_word_t make_word(input logic kind, input logic [2:0] status,
                                         input logic [3:0] id, input logic run_end);
    hk_word_t w;
    w.kind      = kind;
    w.status    = status;
    w.report_id = id;
    w.flags     = enable_mask;
    w.run_end   = run_end;
    return w;
  endfunction

  task automatic clear_collection();
    bytes_seen   = '0;
    declared_cnt = '0;
    bad_id_seen  = 1'b0;
  endtask

  task automatic advance_phase();
    int unsigned span;
    span = (period_q == '0) ? 1 : period_q;
    phase_q = phase_q + 1'b1;
    if (phase_q >= span) begin
      phase_q = '0;
      for (int id = 1; id <= NumStructures; id++) begin
        if (enable_mask[id-1]) begin
          awaited_words.push_back(make_word(KindReport, StatOk, 4'(id),
                                            (enable_mask >> id) == '0));
        end
      end
    end
  endtask

  task automatic close_telecommand(input logic [1:0] sub);
    logic [2:0] verdict;
    if (sub == SubOther) begin
      verdict = StatUnknownSub;
    end else if (bytes_seen != declared_cnt + 1) begin
      verdict = StatBadLength;
    end else if (declared_cnt == 0) begin
      verdict = StatBadParam;
    end else if (declared_cnt > MaxList) begin
      verdict = StatTooLong;
    end else if (bad_id_seen) begin
      verdict = StatUnknownId;
    end else begin
      verdict = StatOk;
    end
    if (verdict == StatOk) begin
      for (int i = 0; i < declared_cnt; i++) begin
        case (sub)
          SubEnable: begin
            enable_mask[id_list[i] - 1] = 1'b1;
          end
          SubDisable: begin
            enable_mask[id_list[i] - 1] = 1'b0;
          end
          default: begin
            awaited_words.push_back(make_word(KindReport, StatOk, id_list[i][3:0], 1'b0));
          end
        endcase
      end
    end
    awaited_words.push_back(make_word(KindStatus, verdict, 4'd0, 1'b1));
    clear_collection();
  endtask

  task automatic take_tc_byte(input logic [1:0] sub, input logic has, input logic [7:0] data,
                              input logic fin);
    if (!has) begin
      awaited_words.push_back(make_word(KindStatus,
                                        (sub == SubOther) ? StatUnknownSub : StatBadLength,
                                        4'd0, 1'b1));
      clear_collection();
      return;
    end
    if (bytes_seen == '0) begin
      declared_cnt = data;
    end else begin
      if (bytes_seen - 1 < MaxList) id_list[bytes_seen - 1] = data;
      if (data < 1 || data > NumStructures) bad_id_seen = 1'b1;
    end
    if (bytes_seen != '1) bytes_seen = bytes_seen + 1'b1;
    if (fin) close_telecommand(sub);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      error_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_words.delete();
      period_q    = PeriodW'(PeriodRst);
      phase_q     = '0;
      enable_mask = 8'h01;
      error_cnt   = 0;
      clear_collection();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_word = {kind_i, status_i, report_id_i, enabled_flags_i, run_end_i};
        if (awaited_words.size() == 0) begin
          error_cnt++;
          $display("%0t: unexpected word, expected none, actual kind=%0d status=%0d id=%0d flags=%h end=%0d",
                   $time, kind_i, status_i, report_id_i, enabled_flags_i, run_end_i);
        end else begin
          want_word = awaited_words.pop_front();
          check_field("kind", want_word.kind, got_word.kind);
          check_field("status", want_word.status, got_word.status);
          check_field("report_id", want_word.report_id, got_word.report_id);
          check_field("enabled_flags", want_word.flags, got_word.flags);
          check_field("run_end", want_word.run_end, got_word.run_end);
        end
      end
      if (cfg_valid_i && cfg_ready_i) period_q = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        if (opcode_i == OpTick) advance_phase();
        else take_tc_byte(subtype_i, has_byte_i, data_byte_i, last_i);
      end
      errors_o  <= error_cnt;
      pending_o <= awaited_words.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the housekeeping report scheduler testbench: clock, reset, stimulus and verdict.
// Depends on hrs_pkg, housekeeping_report_scheduler and hk_report_checker.
module testbench;
  import hrs_pkg::*;

  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned SettleCycles  = NumStructures + 4;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        opcode      = 1'b0;
  logic [1:0]  subtype     = 2'd0;
  logic        has_byte    = 1'b0;
  logic [7:0]  data_byte   = 8'd0;
  logic        last        = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic [15:0] cfg_data    = 16'd0;
  logic        out_ready   = 1'b0;
  logic        gaps_on     = 1'b1;
  logic        hold_off_go = 1'b0;
  logic        ready_held  = 1'b0;
  logic        in_ready;
  logic        cfg_ready;
  logic        out_valid;
  logic        kind;
  logic [2:0]  status;
  logic [3:0]  report_id;
  logic [7:0]  enabled_flags;
  logic        run_end;
  int unsigned errors;
  int unsigned pending;
  int unsigned words_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned phase_end;
  logic [7:0]  tc_bytes[$];

  housekeeping_report_scheduler uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .subtype_i       (subtype),
    .has_byte_i      (has_byte),
    .data_byte_i     (data_byte),
    .last_i          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .kind_o          (kind),
    .status_o        (status),
    .report_id_o     (report_id),
    .enabled_flags_o (enabled_flags),
    .run_end_o       (run_end)
  );

  hk_report_checker hk_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .opcode_i        (opcode),
    .subtype_i       (subtype),
    .has_byte_i      (has_byte),
    .data_byte_i     (data_byte),
    .last_i          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .kind_i          (kind),
    .status_i        (status),
    .report_id_i     (report_id),
    .enabled_flags_i (enabled_flags),
    .run_end_i       (run_end),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver holds off once for a long stretch so that the block fills up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_go && !ready_held) begin
        ready_held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      out_ready <= !(gaps_on && $urandom_range(99) < 17);
    end
  end

  task automatic send_word(input logic op, input logic [1:0] sub, input logic hb,
                           input logic [7:0] data, input logic fin);
    if (gaps_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    subtype   <= sub;
    has_byte  <= hb;
    data_byte <= data;
    last      <= fin;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(OpTick, 2'($urandom_range(3)), 1'($urandom_range(1)), 8'($urandom),
              1'($urandom_range(1)));
  endtask

  task automatic send_tc(input logic [1:0] sub);
    int unsigned final_idx;
    final_idx = tc_bytes.size() - 1;
    for (int i = 0; i < tc_bytes.size(); i++) begin
      if ($urandom_range(99) < 8) send_tick();
      send_word(OpTc, (i == final_idx) ? sub : 2'($urandom_range(3)), 1'b1, tc_bytes[i],
                i == final_idx);
    end
  endtask

  task automatic send_random_command();
    int unsigned pick;
    int unsigned count;
    logic [1:0]  sub;
    pick = $urandom_range(99);
    tc_bytes.delete();
    if (pick < 10) begin
      send_tick();
    end else if (pick < 22) begin
      send_word(OpTc, 2'($urandom_range(3)), 1'b0, 8'($urandom), 1'($urandom_range(1)));
    end else if (pick < 37) begin
      tc_bytes.push_back(8'($urandom_range(5)));
      repeat ($urandom_range(5)) tc_bytes.push_back(8'($urandom_range(NumStructures + 1)));
      send_tc(2'($urandom_range(3)));
    end else begin
      sub   = ($urandom_range(19) == 0) ? SubOther : 2'($urandom_range(2));
      count = ($urandom_range(14) == 0) ? $urandom_range(MaxList, MaxList + 1)
                                        : $urandom_range(1, 4);
      tc_bytes.push_back(8'(count));
      repeat (count) begin
        tc_bytes.push_back(($urandom_range(99) < 8) ? 8'($urandom)
                                                    : 8'($urandom_range(1, NumStructures)));
      end
      send_tc(sub);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_period(input logic [15:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    write_period(16'd1);
    send_tick();
    send_word(OpTc, SubEnable, 1'b0, 8'hFF, 1'b1);
    send_word(OpTc, SubOther, 1'b0, 8'h00, 1'b0);
    tc_bytes = {8'd1, 8'd8};
    send_tc(SubEnable);
    send_tick();
    send_word(OpTc, SubOneShot, 1'b1, 8'd2, 1'b0);
    send_tick();
    send_word(OpTc, SubOneShot, 1'b1, 8'd8, 1'b0);
    send_word(OpTc, SubOneShot, 1'b1, 8'd1, 1'b1);
    tc_bytes = {8'd0};
    send_tc(SubDisable);
    tc_bytes = {8'd2, 8'd1};
    send_tc(SubEnable);
    tc_bytes = {8'd2, 8'd0, 8'd255};
    send_tc(SubEnable);
    tc_bytes = {8'd1, 8'd1};
    send_tc(SubOther);
    send_word(OpTc, SubDisable, 1'b1, 8'd3, 1'b0);
    send_word(OpTc, SubDisable, 1'b0, 8'd5, 1'b1);
    tc_bytes = {8'd1, 8'd1};
    send_tc(SubDisable);
    tc_bytes = {8'd255};
    send_tc(SubOneShot);
    write_period(16'd0);
    send_tick();

    write_period(16'd3);
    phase_end = words_sent + 8;
    while (words_sent < phase_end) send_random_command();
    hold_off_go <= 1'b1;
    tc_bytes.delete();
    tc_bytes.push_back(8'(MaxList));
    repeat (MaxList) tc_bytes.push_back(8'($urandom_range(1, NumStructures)));
    send_tc(SubOneShot);
    phase_end = words_sent + 18;
    while (words_sent < phase_end) send_random_command();

    gaps_on <= 1'b0;
    write_period(16'hFFFF);
    phase_end = words_sent + 18;
    while (words_sent < phase_end) send_random_command();

    gaps_on <= 1'b1;
    write_period(16'($urandom_range(2, 5)));
    phase_end = words_sent + 14;
    while (words_sent < phase_end) send_random_command();

    settle();
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/hrs_pkg.sv
rtl/core/housekeeping_report_scheduler.sv
tb/hk_report_checker.sv
tb/testbench.sv
